### rtl/shtb_pkg.sv
// ----------------------------------------------------------------------------
// shtb_pkg
// Types, codes and constants shared by the two-wire sensor bus master.
// ----------------------------------------------------------------------------
package shtb_pkg;

    // command field codes on the input side
    localparam logic [2:0] CMD_CODE_NONE = 3'd0;
    localparam logic [2:0] CMD_CODE_TEMP = 3'd1;
    localparam logic [2:0] CMD_CODE_HUMI = 3'd2;
    localparam logic [2:0] CMD_CODE_SOFT = 3'd3;
    localparam logic [2:0] CMD_CODE_CONN = 3'd4;

    // command bytes sent on the wire
    localparam logic [7:0] BYTE_TEMP       = 8'h03;
    localparam logic [7:0] BYTE_HUMI       = 8'h05;
    localparam logic [7:0] BYTE_SOFT_RESET = 8'h1e;

    localparam logic [3:0] CONN_PULSES   = 4'd9;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // reset values of the configuration registers
    localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
    localparam logic [23:0] RESET_WAIT_RST  = 24'd100000;

    // start pattern, bit i is step i
    localparam logic [6:0] START_SCK  = 7'b0110110;
    localparam logic [6:0] START_DLOW = 7'b0011100;

    // queue geometry, both queues
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PHASE_TICKS = 2'd0,
        CFG_RESET_WAIT  = 2'd1
    } t_cfg_reg;

    // classified command
    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_TEMP = 3'd1,
        CMD_HUMI = 3'd2,
        CMD_SOFT = 3'd3,
        CMD_CONN = 3'd4
    } t_cmd;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE       = 5'd0,
        ST_CR_PRE     = 5'd1,
        ST_CR_HI      = 5'd2,
        ST_CR_LO      = 5'd3,
        ST_START0     = 5'd4,
        ST_START1     = 5'd5,
        ST_START2     = 5'd6,
        ST_START3     = 5'd7,
        ST_START4     = 5'd8,
        ST_START5     = 5'd9,
        ST_START6     = 5'd10,
        ST_WR_LO      = 5'd11,
        ST_WR_HI      = 5'd12,
        ST_ACK_LO     = 5'd13,
        ST_ACK_HI     = 5'd14,
        ST_ACK_END    = 5'd15,
        ST_WAIT_READY = 5'd16,
        ST_RD_HI      = 5'd17,
        ST_RD_LO      = 5'd18,
        ST_RD_ACK_LO  = 5'd19,
        ST_RD_ACK_HI  = 5'd20,
        ST_RD_ACK_END = 5'd21,
        ST_RESET_WAIT = 5'd22
    } t_state;

    // input beat
    typedef struct packed {
        logic [2:0] command;
        logic       data_in;
    } t_in;

    // result beat
    typedef struct packed {
        logic        sck;
        logic        data_low;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
        logic [15:0] reading;
        logic [7:0]  checksum;
    } t_out;

    // classified tick handed from front to sequencer
    typedef struct packed {
        t_cmd cmd;
        logic data_in;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work work;
    } t_work_beat;

    typedef struct packed {
        logic valid;
        t_out res;
    } t_res_beat;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [23:0] data;
    } t_cfg_wr;

    // command code to class, unused codes act as none
    function automatic t_cmd classify(input logic [2:0] code);
        t_cmd c;
        unique case (code)
            CMD_CODE_TEMP: c = CMD_TEMP;
            CMD_CODE_HUMI: c = CMD_HUMI;
            CMD_CODE_SOFT: c = CMD_SOFT;
            CMD_CODE_CONN: c = CMD_CONN;
            default:       c = CMD_NONE;
        endcase
        return c;
    endfunction

    // class to wire byte, connection reset sends none
    function automatic logic [7:0] cmd_byte(input t_cmd c);
        logic [7:0] b;
        unique case (c)
            CMD_TEMP: b = BYTE_TEMP;
            CMD_HUMI: b = BYTE_HUMI;
            CMD_SOFT: b = BYTE_SOFT_RESET;
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/shtb_front.sv
// ----------------------------------------------------------------------------
// shtb_front
// Accepts input beats, classifies the command and queues the tick.
// ----------------------------------------------------------------------------
module shtb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  shtb_pkg::t_in      i_in,
    output logic               full,
    output shtb_pkg::t_work_beat o_work,
    input  logic               i_work_take
);

    shtb_pkg::t_work                       r_q [shtb_pkg::Q_DEPTH];
    logic [shtb_pkg::Q_PTR_W-1:0]          r_wr_ptr;
    logic [shtb_pkg::Q_PTR_W-1:0]          r_rd_ptr;
    logic [shtb_pkg::Q_CNT_W-1:0]          r_count;
    logic                                  wr_en;
    logic                                  rd_en;

    assign full  = (r_count == shtb_pkg::Q_CNT_W'(shtb_pkg::Q_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = i_work_take && (r_count != '0);

    // queue storage, payload without reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= '{cmd: shtb_pkg::classify(i_in.command), data_in: i_in.data_in};
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd_en) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (wr_en && !rd_en) r_count <= r_count + 1'b1;
            else if (rd_en && !wr_en) r_count <= r_count - 1'b1;
        end
    end

    assign o_work.valid = (r_count != '0);
    assign o_work.work  = r_q[r_rd_ptr];

endmodule

### rtl/shtb_seq.sv
// ----------------------------------------------------------------------------
// shtb_seq
// Bit sequencer: one queued tick per cycle if space; drives pins, reads bytes.
// ----------------------------------------------------------------------------
module shtb_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shtb_pkg::t_cfg_wr    i_cfg,
    input  shtb_pkg::t_work_beat i_work,
    input  logic                 i_space,
    output logic                 o_work_take,
    output shtb_pkg::t_res_beat  o_res
);

    shtb_pkg::t_state r_state, n_state;
    logic [15:0] r_phase, n_phase;
    logic [3:0]  r_bit, n_bit;
    logic [1:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_cmd_byte, n_cmd_byte;
    logic [15:0] r_reading, n_reading;
    logic [7:0]  r_checksum, n_checksum;
    logic        r_ack_err, n_ack_err;
    logic [23:0] r_wait, n_wait;
    logic [15:0] r_phase_ticks;
    logic [23:0] r_reset_wait;

    logic        take;
    logic        d;
    logic        n_done;
    logic [15:0] pt;
    logic [15:0] phase_inc;
    logic [3:0]  bit_inc;
    logic [2:0]  start_idx;
    logic        sck;
    logic        dlow;

    assign take        = i_work.valid && i_space;
    assign o_work_take = take;
    assign d           = i_work.work.data_in;
    assign pt          = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;
    assign phase_inc   = r_phase + 16'd1;
    assign bit_inc     = r_bit + 4'd1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= shtb_pkg::PHASE_TICKS_RST;
            r_reset_wait  <= shtb_pkg::RESET_WAIT_RST;
        end else if (i_cfg.valid) begin
            unique case (shtb_pkg::t_cfg_reg'(i_cfg.index))
                shtb_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg.data[15:0];
                shtb_pkg::CFG_RESET_WAIT:  r_reset_wait  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // next state for one tick
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_byte     = r_byte;
        n_shift    = r_shift;
        n_cmd_byte = r_cmd_byte;
        n_reading  = r_reading;
        n_checksum = r_checksum;
        n_ack_err  = r_ack_err;
        n_wait     = r_wait;
        n_done     = 1'b0;
        if (take) begin
            unique case (r_state)
                shtb_pkg::ST_IDLE: begin
                    if (i_work.work.cmd != shtb_pkg::CMD_NONE) begin
                        n_ack_err  = 1'b0;
                        n_bit      = '0;
                        n_byte     = '0;
                        n_shift    = '0;
                        n_phase    = '0;
                        n_wait     = '0;
                        n_cmd_byte = shtb_pkg::cmd_byte(i_work.work.cmd);
                        n_state    = (i_work.work.cmd == shtb_pkg::CMD_CONN) ?
                                     shtb_pkg::ST_CR_PRE : shtb_pkg::ST_START0;
                    end
                end
                shtb_pkg::ST_WAIT_READY: begin
                    if (!d) begin
                        n_bit   = '0;
                        n_byte  = '0;
                        n_shift = '0;
                        n_phase = '0;
                        n_state = shtb_pkg::ST_RD_HI;
                    end
                end
                shtb_pkg::ST_RESET_WAIT: begin
                    if (r_wait >= r_reset_wait) begin
                        n_state = shtb_pkg::ST_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_wait = r_wait + 24'd1;
                    end
                end
                default: begin
                    n_phase = phase_inc;
                    if (phase_inc >= pt) begin
                        n_phase = '0;
                        // end of a pin step
                        unique case (r_state)
                            shtb_pkg::ST_START0, shtb_pkg::ST_START1, shtb_pkg::ST_START2,
                            shtb_pkg::ST_START3, shtb_pkg::ST_START4,
                            shtb_pkg::ST_START5: begin
                                n_state = shtb_pkg::t_state'(r_state + 5'd1);
                            end
                            shtb_pkg::ST_CR_PRE: begin
                                n_bit   = '0;
                                n_state = shtb_pkg::ST_CR_HI;
                            end
                            shtb_pkg::ST_CR_HI: n_state = shtb_pkg::ST_CR_LO;
                            shtb_pkg::ST_CR_LO: begin
                                n_bit   = bit_inc;
                                n_state = (bit_inc < shtb_pkg::CONN_PULSES) ?
                                          shtb_pkg::ST_CR_HI : shtb_pkg::ST_START0;
                            end
                            shtb_pkg::ST_START6: begin
                                if (r_cmd_byte == '0) begin
                                    n_state = shtb_pkg::ST_RESET_WAIT;
                                    n_wait  = '0;
                                end else begin
                                    n_bit   = '0;
                                    n_state = shtb_pkg::ST_WR_LO;
                                end
                            end
                            shtb_pkg::ST_WR_LO: n_state = shtb_pkg::ST_WR_HI;
                            shtb_pkg::ST_WR_HI: begin
                                n_bit   = bit_inc;
                                n_state = (bit_inc < shtb_pkg::BITS_PER_BYTE) ?
                                          shtb_pkg::ST_WR_LO : shtb_pkg::ST_ACK_LO;
                            end
                            shtb_pkg::ST_ACK_LO: n_state = shtb_pkg::ST_ACK_HI;
                            shtb_pkg::ST_ACK_HI: begin
                                n_ack_err = d;
                                n_state   = shtb_pkg::ST_ACK_END;
                            end
                            shtb_pkg::ST_ACK_END: begin
                                if (r_cmd_byte == shtb_pkg::BYTE_SOFT_RESET) begin
                                    n_state = shtb_pkg::ST_RESET_WAIT;
                                    n_wait  = '0;
                                end else begin
                                    n_state = shtb_pkg::ST_WAIT_READY;
                                end
                            end
                            shtb_pkg::ST_RD_HI: begin
                                n_shift = {r_shift[6:0], d};
                                n_state = shtb_pkg::ST_RD_LO;
                            end
                            shtb_pkg::ST_RD_LO: begin
                                n_bit   = bit_inc;
                                n_state = (bit_inc < shtb_pkg::BITS_PER_BYTE) ?
                                          shtb_pkg::ST_RD_HI : shtb_pkg::ST_RD_ACK_LO;
                            end
                            shtb_pkg::ST_RD_ACK_LO: n_state = shtb_pkg::ST_RD_ACK_HI;
                            shtb_pkg::ST_RD_ACK_HI: n_state = shtb_pkg::ST_RD_ACK_END;
                            shtb_pkg::ST_RD_ACK_END: begin
                                priority if (r_byte == 2'd0) n_reading[15:8] = r_shift;
                                else if (r_byte == 2'd1) n_reading[7:0] = r_shift;
                                else n_checksum = r_shift;
                                if (r_byte >= 2'd2) begin
                                    n_byte  = '0;
                                    n_state = shtb_pkg::ST_IDLE;
                                    n_done  = 1'b1;
                                end else begin
                                    n_byte  = r_byte + 2'd1;
                                    n_bit   = '0;
                                    n_shift = '0;
                                    n_state = shtb_pkg::ST_RD_HI;
                                end
                            end
                            default: n_state = shtb_pkg::ST_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    // pin levels after the tick's update
    assign start_idx = 3'(n_state - shtb_pkg::ST_START0);

    always_comb begin
        sck  = 1'b0;
        dlow = 1'b0;
        unique case (n_state)
            shtb_pkg::ST_START0, shtb_pkg::ST_START1, shtb_pkg::ST_START2,
            shtb_pkg::ST_START3, shtb_pkg::ST_START4, shtb_pkg::ST_START5,
            shtb_pkg::ST_START6: begin
                sck  = shtb_pkg::START_SCK[start_idx];
                dlow = shtb_pkg::START_DLOW[start_idx];
            end
            shtb_pkg::ST_CR_HI, shtb_pkg::ST_ACK_HI, shtb_pkg::ST_RD_HI: sck = 1'b1;
            shtb_pkg::ST_WR_LO, shtb_pkg::ST_WR_HI: begin
                sck  = (n_state == shtb_pkg::ST_WR_HI);
                dlow = !n_cmd_byte[3'd7 - n_bit[2:0]];
            end
            shtb_pkg::ST_RD_ACK_LO, shtb_pkg::ST_RD_ACK_HI: begin
                sck  = (n_state == shtb_pkg::ST_RD_ACK_HI);
                dlow = (n_byte < 2'd2);
            end
            default: ;
        endcase
    end

    assign o_res.valid         = take;
    assign o_res.res.sck       = sck;
    assign o_res.res.data_low  = dlow;
    assign o_res.res.busy_res  = (n_state != shtb_pkg::ST_IDLE);
    assign o_res.res.done_res  = n_done;
    assign o_res.res.ack_error = n_ack_err;
    assign o_res.res.reading   = n_reading;
    assign o_res.res.checksum  = n_checksum;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shtb_pkg::ST_IDLE;
            r_phase    <= '0;
            r_bit      <= '0;
            r_byte     <= '0;
            r_shift    <= '0;
            r_cmd_byte <= '0;
            r_reading  <= '0;
            r_checksum <= '0;
            r_ack_err  <= 1'b0;
            r_wait     <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_byte     <= n_byte;
            r_shift    <= n_shift;
            r_cmd_byte <= n_cmd_byte;
            r_reading  <= n_reading;
            r_checksum <= n_checksum;
            r_ack_err  <= n_ack_err;
            r_wait     <= n_wait;
        end
    end

endmodule

### rtl/shtb_outq.sv
// ----------------------------------------------------------------------------
// shtb_outq
// Result queue between the sequencer and the consumer.
// ----------------------------------------------------------------------------
module shtb_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shtb_pkg::t_res_beat i_res,
    output logic                o_space,
    output logic                empty,
    input  logic                pop,
    output shtb_pkg::t_out      o_out
);

    shtb_pkg::t_out                        r_q [shtb_pkg::Q_DEPTH];
    logic [shtb_pkg::Q_PTR_W-1:0]          r_wr_ptr;
    logic [shtb_pkg::Q_PTR_W-1:0]          r_rd_ptr;
    logic [shtb_pkg::Q_CNT_W-1:0]          r_count;
    logic                                  rd_en;

    assign empty   = (r_count == '0);
    assign o_space = (r_count != shtb_pkg::Q_CNT_W'(shtb_pkg::Q_DEPTH));
    assign rd_en   = pop && !empty;

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_res.valid) r_q[r_wr_ptr] <= i_res.res;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_res.valid) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd_en) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_res.valid && !rd_en) r_count <= r_count + 1'b1;
            else if (rd_en && !i_res.valid) r_count <= r_count - 1'b1;
        end
    end

    assign o_out = r_q[r_rd_ptr];

endmodule

### rtl/sht_sensor_bus_master_core.sv
// ----------------------------------------------------------------------------
// sht_sensor_bus_master_core
// Two-wire humidity/temperature sensor bus master, one tick per beat.
//
//   channel   direction  handshake            beat
//   input     in         push / full          i_in  (command, data_in)
//   result    out        pop / empty          o_out (pins, status, reading)
//   config    in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// One input beat gives one result beat, via the tick queue and the result queue.
// The sequencer retires one tick every cycle while the result queue has space,
// so the sustained rate is one beat per cycle while the result side pops.
// Reset is synchronous and empties both queues; the block then accepts at once.
// A stalled result side fills the result queue and then the tick queue,
// after which full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module sht_sensor_bus_master_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  shtb_pkg::t_in   i_in,
    output logic            empty,
    input  logic            pop,
    output shtb_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [23:0]     i_cfg_data
);

    shtb_pkg::t_work_beat work;
    shtb_pkg::t_res_beat  res;
    shtb_pkg::t_cfg_wr    cfg;
    logic                 work_take;
    logic                 space;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // front: accept and classify
    shtb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .o_work      (work),
        .i_work_take (work_take)
    );

    // back: bit sequencer
    shtb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_work      (work),
        .i_space     (space),
        .o_work_take (work_take),
        .o_res       (res)
    );

    // result queue
    shtb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_space (space),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

endmodule

### rtl/shtb_checker.sv
// ----------------------------------------------------------------------------
// shtb_checker
// Port-level checks on the sensor bus master, bound to the top level.
// ----------------------------------------------------------------------------
module shtb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input shtb_pkg::t_out o_out
);

    // queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a completing beat already shows the idle bus
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.done_res) |-> !o_out.busy_res)
        else $error("done beat still busy");

    // an idle beat releases both lines
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.busy_res) |-> (!o_out.sck && !o_out.data_low))
        else $error("pins driven while idle");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed");

endmodule

bind sht_sensor_bus_master_core shtb_checker u_shtb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

### bench/sht_sensor_bus_master_core_tb.sv
// ----------------------------------------------------------------------------
// sht_sensor_bus_master_core_tb
// Checks the two-wire sensor bus master tick by tick. A model inside the bench
// follows the sequencer state for every accepted tick beat and predicts the pin,
// status and reading beat. Each popped result beat is compared with the oldest
// prediction. Directed tests cover each command, unused codes, the ack error,
// the late-sensor wait, all-ones and all-zeros readings, zero phase
// ticks, zero and short reset wait, and a phase change in mid-sequence.
// Random traffic with idle and stall phases and a long result hold-off follows.
// ----------------------------------------------------------------------------
module sht_sensor_bus_master_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CODE_MAX = 3'd7;
    localparam int DATA_RANDOM = 0;
    localparam int DATA_ONES   = 1;
    localparam int DATA_ZEROS  = 2;

    // block ports
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           push        = 1'b0;
    logic           full;
    shtb_pkg::t_in  i_in        = '0;
    logic           empty;
    logic           pop         = 1'b0;
    shtb_pkg::t_out o_out;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index = shtb_pkg::CFG_PHASE_TICKS;
    logic [23:0]    i_cfg_data  = '0;

    // traffic shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int mismatches     = 0;

    // predicted result beats, oldest first
    shtb_pkg::t_out bus_beats[$];

    // sequencer state as the bench sees it
    shtb_pkg::t_state bus_st = shtb_pkg::ST_IDLE;
    logic [15:0] ph_cnt    = '0;
    logic [3:0]  bit_idx   = '0;
    logic [1:0]  byte_idx  = '0;
    logic [7:0]  shreg     = '0;
    logic [7:0]  wire_byte = '0;
    logic [15:0] value_reg = '0;
    logic [7:0]  crc_reg   = '0;
    logic        ack_err   = 1'b0;
    logic [23:0] wait_cnt  = '0;
    logic [15:0] cfg_phase = shtb_pkg::PHASE_TICKS_RST;
    logic [23:0] cfg_wait  = shtb_pkg::RESET_WAIT_RST;

    sht_sensor_bus_master_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // one tick of the sequencer, returns the pin and status beat
    function automatic shtb_pkg::t_out bus_tick(shtb_pkg::t_in beat);
        shtb_pkg::t_out res;
        logic [15:0]    pt;
        logic [2:0]     step;
        logic           fin;
        logic           d;
        fin = 1'b0;
        d   = beat.data_in;
        pt  = (cfg_phase == 16'd0) ? 16'd1 : cfg_phase;
        if (bus_st == shtb_pkg::ST_IDLE) begin
            // new command, unused codes act as none
            if (beat.command >= shtb_pkg::CMD_CODE_TEMP &&
                beat.command <= shtb_pkg::CMD_CODE_CONN) begin
                ack_err  = 1'b0;
                bit_idx  = '0;
                byte_idx = '0;
                shreg    = '0;
                ph_cnt   = '0;
                wait_cnt = '0;
                case (beat.command)
                    shtb_pkg::CMD_CODE_TEMP: wire_byte = shtb_pkg::BYTE_TEMP;
                    shtb_pkg::CMD_CODE_HUMI: wire_byte = shtb_pkg::BYTE_HUMI;
                    shtb_pkg::CMD_CODE_SOFT: wire_byte = shtb_pkg::BYTE_SOFT_RESET;
                    default:                 wire_byte = 8'h00;
                endcase
                bus_st = (beat.command == shtb_pkg::CMD_CODE_CONN) ?
                         shtb_pkg::ST_CR_PRE : shtb_pkg::ST_START0;
            end
        end else if (bus_st == shtb_pkg::ST_WAIT_READY) begin
            // sensor pulls data low when the value is ready
            if (!d) begin
                bit_idx  = '0;
                byte_idx = '0;
                shreg    = '0;
                ph_cnt   = '0;
                bus_st   = shtb_pkg::ST_RD_HI;
            end
        end else if (bus_st == shtb_pkg::ST_RESET_WAIT) begin
            if (wait_cnt >= cfg_wait) begin
                bus_st = shtb_pkg::ST_IDLE;
                fin    = 1'b1;
            end else begin
                wait_cnt = wait_cnt + 24'd1;
            end
        end else begin
            // pin step timing
            ph_cnt = ph_cnt + 16'd1;
            if (ph_cnt >= pt) begin
                ph_cnt = '0;
                case (bus_st)
                    shtb_pkg::ST_START0, shtb_pkg::ST_START1, shtb_pkg::ST_START2,
                    shtb_pkg::ST_START3, shtb_pkg::ST_START4, shtb_pkg::ST_START5:
                        bus_st = shtb_pkg::t_state'(bus_st + 5'd1);
                    shtb_pkg::ST_CR_PRE: begin
                        bit_idx = '0;
                        bus_st  = shtb_pkg::ST_CR_HI;
                    end
                    shtb_pkg::ST_CR_HI: bus_st = shtb_pkg::ST_CR_LO;
                    shtb_pkg::ST_CR_LO: begin
                        bit_idx = bit_idx + 4'd1;
                        bus_st  = (bit_idx < shtb_pkg::CONN_PULSES) ?
                                  shtb_pkg::ST_CR_HI : shtb_pkg::ST_START0;
                    end
                    shtb_pkg::ST_START6: begin
                        if (wire_byte == 8'h00) begin
                            bus_st   = shtb_pkg::ST_RESET_WAIT;
                            wait_cnt = '0;
                        end else begin
                            bit_idx = '0;
                            bus_st  = shtb_pkg::ST_WR_LO;
                        end
                    end
                    shtb_pkg::ST_WR_LO: bus_st = shtb_pkg::ST_WR_HI;
                    shtb_pkg::ST_WR_HI: begin
                        bit_idx = bit_idx + 4'd1;
                        bus_st  = (bit_idx < shtb_pkg::BITS_PER_BYTE) ?
                                  shtb_pkg::ST_WR_LO : shtb_pkg::ST_ACK_LO;
                    end
                    shtb_pkg::ST_ACK_LO: bus_st = shtb_pkg::ST_ACK_HI;
                    shtb_pkg::ST_ACK_HI: begin
                        ack_err = d;
                        bus_st  = shtb_pkg::ST_ACK_END;
                    end
                    shtb_pkg::ST_ACK_END: begin
                        if (wire_byte == shtb_pkg::BYTE_SOFT_RESET) begin
                            bus_st   = shtb_pkg::ST_RESET_WAIT;
                            wait_cnt = '0;
                        end else begin
                            bus_st = shtb_pkg::ST_WAIT_READY;
                        end
                    end
                    shtb_pkg::ST_RD_HI: begin
                        shreg  = {shreg[6:0], d};
                        bus_st = shtb_pkg::ST_RD_LO;
                    end
                    shtb_pkg::ST_RD_LO: begin
                        bit_idx = bit_idx + 4'd1;
                        bus_st  = (bit_idx < shtb_pkg::BITS_PER_BYTE) ?
                                  shtb_pkg::ST_RD_HI : shtb_pkg::ST_RD_ACK_LO;
                    end
                    shtb_pkg::ST_RD_ACK_LO: bus_st = shtb_pkg::ST_RD_ACK_HI;
                    shtb_pkg::ST_RD_ACK_HI: bus_st = shtb_pkg::ST_RD_ACK_END;
                    shtb_pkg::ST_RD_ACK_END: begin
                        case (byte_idx)
                            2'd0:    value_reg[15:8] = shreg;
                            2'd1:    value_reg[7:0]  = shreg;
                            default: crc_reg         = shreg;
                        endcase
                        if (byte_idx >= 2'd2) begin
                            byte_idx = '0;
                            bus_st   = shtb_pkg::ST_IDLE;
                            fin      = 1'b1;
                        end else begin
                            byte_idx = byte_idx + 2'd1;
                            bit_idx  = '0;
                            shreg    = '0;
                            bus_st   = shtb_pkg::ST_RD_HI;
                        end
                    end
                    default: bus_st = shtb_pkg::ST_IDLE;
                endcase
            end
        end

        // pin levels of the step now entered
        res = '0;
        if (bus_st >= shtb_pkg::ST_START0 && bus_st <= shtb_pkg::ST_START6) begin
            step         = 3'(bus_st - shtb_pkg::ST_START0);
            res.sck      = shtb_pkg::START_SCK[step];
            res.data_low = shtb_pkg::START_DLOW[step];
        end
        case (bus_st)
            shtb_pkg::ST_CR_HI, shtb_pkg::ST_ACK_HI, shtb_pkg::ST_RD_HI: res.sck = 1'b1;
            shtb_pkg::ST_WR_LO, shtb_pkg::ST_WR_HI: begin
                res.sck      = (bus_st == shtb_pkg::ST_WR_HI);
                res.data_low = !wire_byte[3'd7 - bit_idx[2:0]];
            end
            shtb_pkg::ST_RD_ACK_LO, shtb_pkg::ST_RD_ACK_HI: begin
                res.sck      = (bus_st == shtb_pkg::ST_RD_ACK_HI);
                res.data_low = (byte_idx < 2'd2);
            end
            default: ;
        endcase
        res.busy_res  = (bus_st != shtb_pkg::ST_IDLE);
        res.done_res  = fin;
        res.ack_error = ack_err;
        res.reading   = value_reg;
        res.checksum  = crc_reg;
        return res;
    endfunction

    // command offered while a sequence runs, always nonzero near completion
    function automatic logic [2:0] busy_code();
        logic [2:0] c;
        if (bus_st == shtb_pkg::ST_RESET_WAIT || bus_st == shtb_pkg::ST_RD_ACK_END)
            c = 3'($urandom_range(shtb_pkg::CMD_CODE_TEMP, CODE_MAX));
        else if ($urandom_range(3) == 0)
            c = 3'($urandom_range(CODE_MAX));
        else
            c = shtb_pkg::CMD_CODE_NONE;
        return c;
    endfunction

    // command offered while idle, mostly real commands
    function automatic logic [2:0] idle_code();
        logic [2:0] c;
        int         r;
        r = $urandom_range(99);
        if (r < 70)
            c = 3'($urandom_range(shtb_pkg::CMD_CODE_TEMP, shtb_pkg::CMD_CODE_CONN));
        else if (r < 85)
            c = shtb_pkg::CMD_CODE_NONE;
        else
            c = 3'($urandom_range(shtb_pkg::CMD_CODE_CONN + 3'd1, CODE_MAX));
        return c;
    endfunction

    // sensor data level for the next tick
    function automatic logic pick_data(int pattern, int waited);
        logic d;
        if (bus_st == shtb_pkg::ST_WAIT_READY) begin
            case (pattern)
                DATA_ONES:  d = (waited < 12);
                DATA_ZEROS: d = 1'b0;
                default:    d = ($urandom_range(2) != 0);
            endcase
        end else begin
            case (pattern)
                DATA_ONES:  d = 1'b1;
                DATA_ZEROS: d = 1'b0;
                default:    d = 1'($urandom_range(1));
            endcase
        end
        return d;
    endfunction

    // push one tick beat, called and returning at a falling edge
    task automatic send_tick(logic [2:0] code, logic d);
        shtb_pkg::t_in beat;
        beat.command = code;
        beat.data_in = d;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= beat;
        do @(posedge i_clk); while (full);
        bus_beats.push_back(bus_tick(beat));
        @(negedge i_clk);
    endtask

    // write both registers once the block has drained
    task automatic configure(logic [15:0] phase, logic [23:0] wait_ticks);
        push <= 1'b0;
        while (bus_beats.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= shtb_pkg::CFG_PHASE_TICKS;
        i_cfg_data  <= {8'h00, phase};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_phase = phase;
        @(negedge i_clk);
        i_cfg_index <= shtb_pkg::CFG_RESET_WAIT;
        i_cfg_data  <= wait_ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_wait = wait_ticks;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // keep ticking until the sequencer is back in idle
    task automatic finish_sequence(int pattern);
        int waited;
        waited = 0;
        while (bus_st != shtb_pkg::ST_IDLE) begin
            if (bus_st == shtb_pkg::ST_WAIT_READY)
                waited++;
            send_tick(busy_code(), pick_data(pattern, waited));
        end
    endtask

    // idle ticks with no command and with unused codes
    task automatic test_idle_codes();
        logic [2:0] c;
        configure(16'd1, 24'd0);
        send_tick(shtb_pkg::CMD_CODE_NONE, 1'b0);
        send_tick(shtb_pkg::CMD_CODE_NONE, 1'b1);
        for (c = shtb_pkg::CMD_CODE_CONN + 3'd1; c != shtb_pkg::CMD_CODE_NONE; c++)
            send_tick(c, c[0]);
    endtask

    // soft reset with zero wait, then with zero phase ticks
    task automatic test_soft_reset();
        send_tick(shtb_pkg::CMD_CODE_SOFT, 1'b0);
        finish_sequence(DATA_RANDOM);
        configure(16'd0, 24'd3);
        send_tick(shtb_pkg::CMD_CODE_SOFT, 1'b1);
        finish_sequence(DATA_RANDOM);
    endtask

    // nine pulses, start, wait
    task automatic test_connection_reset();
        configure(16'd1, 24'd4);
        send_tick(shtb_pkg::CMD_CODE_CONN, 1'b1);
        finish_sequence(DATA_ONES);
    endtask

    // missing ack with late sensor and all-ones value, then all-zeros value
    task automatic test_measure_extremes();
        configure(16'd1, 24'hff_ffff);
        send_tick(shtb_pkg::CMD_CODE_TEMP, 1'b1);
        finish_sequence(DATA_ONES);
        send_tick(shtb_pkg::CMD_CODE_HUMI, 1'b0);
        finish_sequence(DATA_ZEROS);
    endtask

    // longest phase, shortened while the start pattern is pending
    task automatic test_slow_phase();
        configure(16'hffff, 24'd2);
        send_tick(shtb_pkg::CMD_CODE_TEMP, 1'b0);
        repeat (20) send_tick(busy_code(), pick_data(DATA_RANDOM, 0));
        configure(16'd1, 24'd2);
        finish_sequence(DATA_RANDOM);
    endtask

    // random commands and sensor data
    task automatic test_random_traffic(int send_pct, int recv_pct, int n);
        logic [2:0] c;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        configure(16'($urandom_range(0, 1)), 24'($urandom_range(0, 6)));
        repeat (n) begin
            c = (bus_st == shtb_pkg::ST_IDLE) ? idle_code() : busy_code();
            send_tick(c, pick_data(DATA_RANDOM, 0));
        end
        finish_sequence(DATA_RANDOM);
    endtask

    // result side holds off long enough for full to rise
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 60;
        send_tick(shtb_pkg::CMD_CODE_TEMP, 1'b0);
        repeat (16) send_tick(busy_code(), pick_data(DATA_RANDOM, 0));
        finish_sequence(DATA_RANDOM);
    endtask

    // result side pop control
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare one field of a result beat
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // result beat checker
    always @(posedge i_clk) begin : check_results
        shtb_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (bus_beats.size() == 0) begin
                $error("result beat with no tick pending");
                mismatches++;
            end else begin
                want = bus_beats.pop_front();
                check_field("sck", 16'(want.sck), 16'(o_out.sck));
                check_field("data_low", 16'(want.data_low), 16'(o_out.data_low));
                check_field("busy_res", 16'(want.busy_res), 16'(o_out.busy_res));
                check_field("done_res", 16'(want.done_res), 16'(o_out.done_res));
                check_field("ack_error", 16'(want.ack_error), 16'(o_out.ack_error));
                check_field("reading", want.reading, o_out.reading);
                check_field("checksum", 16'(want.checksum), 16'(o_out.checksum));
            end
        end
    end

    // test sequence
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_codes();
        test_soft_reset();
        test_connection_reset();
        test_measure_extremes();
        test_slow_phase();
        test_random_traffic(0, 0, 20);
        test_random_traffic(47, 0, 20);
        test_random_traffic(0, 47, 20);
        test_random_traffic(10, 10, 20);
        test_backpressure();
        push <= 1'b0;
        recv_stall_pct = 0;
        while (bus_beats.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/shtb_pkg.sv
rtl/shtb_front.sv
rtl/shtb_seq.sv
rtl/shtb_outq.sv
rtl/sht_sensor_bus_master_core.sv
rtl/shtb_checker.sv
bench/sht_sensor_bus_master_core_tb.sv
